>>> rtl/core/cra_pkg.sv
// shared types and constants of the cell run allocator
package cra_pkg;

  // pool geometry and field widths
  localparam int MAX_CELLS = 256;
  localparam int CELL_W    = $clog2(MAX_CELLS);
  localparam int RUN_W     = CELL_W + 1;
  localparam int PTR_W     = RUN_W + 1;
  localparam int CNT_W     = 32;
  localparam int BYTES_W   = 21;
  localparam int OFF_W     = 20;
  localparam int LG_W      = 4;
  localparam int LG_MAX    = 12;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  // item commands
  typedef enum logic [1:0] {
    CMD_ALLOC_FIRST = 2'd0,
    CMD_ALLOC_AT    = 2'd1,
    CMD_FREE        = 2'd2,
    CMD_CLEAR       = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOMEM   = 2'd2,
    ST_BUSY    = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_SIZE_LOG2 = 2'd0,
    REG_CELLS_IN_USE   = 2'd1
  } reg_idx_t;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_SWEEP,
    OP_ALLOC_SETUP,
    OP_AT_ACCEPT,
    OP_BACK_STEP,
    OP_FF_STEP,
    OP_TAKE_SETUP,
    OP_TAKE_STEP,
    OP_FREE_SETUP,
    OP_FREE_HEAD,
    OP_FREE_MERGE,
    OP_FREE_BACK_SETUP,
    OP_FREE_BACK,
    OP_FILL_SETUP,
    OP_FREE_FILL,
    OP_REPORT
  } op_t;

  // controller states
  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISPATCH,
    S_AT_RD, S_AT_CHK, S_BK_RD, S_BK_CHK,
    S_FF_RD, S_FF_CHK, S_TAKE_SETUP, S_TAKE,
    S_FR_RD, S_FR_CHK, S_FL_RD, S_FL_CHK,
    S_FB_SETUP, S_FB_RD, S_FB_CHK, S_FW_SETUP, S_FW,
    S_CLR, S_REPORT
  } state_t;

  // command from controller to datapath
  typedef struct packed {
    op_t     op;
    status_t code;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic req_bad;
    logic at_bad;
    logic free_bad;
    logic fit;
    logic ff_end;
    logic rd_free;
    logic ptr_zero;
    logic take_last;
    logic head_merge;
    logic cell_zero;
    logic fill_last;
    logic sweep_last;
  } dp_stat_t;

endpackage

>>> rtl/core/cra_ctrl.sv
// controller state machine of the cell run allocator
module cra_ctrl
  import cra_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  state_t  state, state_next;
  status_t code, code_next;

  // state and result code registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      code  <= ST_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  // next state and datapath command
  always_comb begin
    state_next = state;
    code_next  = code;
    cmd.op     = OP_NOP;
    cmd.code   = code;
    busy       = (state != S_IDLE);
    unique case (state)
      S_INIT: begin
        cmd.op = OP_SWEEP;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LATCH;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.cmd) inside
          CMD_ALLOC_FIRST, CMD_ALLOC_AT: begin
            cmd.op = OP_ALLOC_SETUP;
            if (stat.req_bad || (stat.cmd == CMD_ALLOC_AT && stat.at_bad)) begin
              code_next  = ST_INVALID;
              state_next = S_REPORT;
            end else if (stat.cmd == CMD_ALLOC_AT) begin
              state_next = S_AT_RD;
            end else begin
              state_next = S_FF_RD;
            end
          end
          CMD_FREE: begin
            cmd.op = OP_FREE_SETUP;
            if (stat.free_bad) begin
              code_next  = ST_INVALID;
              state_next = S_REPORT;
            end else begin
              state_next = S_FR_RD;
            end
          end
          default: begin
            cmd.op     = OP_SWEEP;
            state_next = S_CLR;
          end
        endcase
      end
      S_AT_RD: state_next = S_AT_CHK;
      S_AT_CHK: begin
        if (!stat.fit) begin
          code_next  = ST_BUSY;
          state_next = S_REPORT;
        end else begin
          cmd.op     = OP_AT_ACCEPT;
          state_next = stat.ptr_zero ? S_TAKE_SETUP : S_BK_RD;
        end
      end
      S_BK_RD: state_next = S_BK_CHK;
      S_BK_CHK: begin
        if (stat.rd_free) begin
          cmd.op     = OP_BACK_STEP;
          state_next = stat.ptr_zero ? S_TAKE_SETUP : S_BK_RD;
        end else begin
          state_next = S_TAKE_SETUP;
        end
      end
      S_FF_RD: state_next = S_FF_CHK;
      S_FF_CHK: begin
        cmd.op = OP_FF_STEP;
        if (stat.fit) begin
          state_next = S_TAKE_SETUP;
        end else if (stat.ff_end) begin
          code_next  = ST_NOMEM;
          state_next = S_REPORT;
        end else begin
          state_next = S_FF_RD;
        end
      end
      S_TAKE_SETUP: begin
        cmd.op     = OP_TAKE_SETUP;
        state_next = S_TAKE;
      end
      S_TAKE: begin
        cmd.op = OP_TAKE_STEP;
        if (stat.take_last) begin
          code_next  = ST_OK;
          state_next = S_REPORT;
        end
      end
      S_FR_RD: state_next = S_FR_CHK;
      S_FR_CHK: begin
        if (stat.rd_free) begin
          code_next  = ST_INVALID;
          state_next = S_REPORT;
        end else begin
          cmd.op     = OP_FREE_HEAD;
          state_next = stat.head_merge ? S_FL_RD : S_FB_SETUP;
        end
      end
      S_FL_RD: state_next = S_FL_CHK;
      S_FL_CHK: begin
        cmd.op     = OP_FREE_MERGE;
        state_next = S_FB_SETUP;
      end
      S_FB_SETUP: begin
        cmd.op     = OP_FREE_BACK_SETUP;
        state_next = stat.cell_zero ? S_FW_SETUP : S_FB_RD;
      end
      S_FB_RD: state_next = S_FB_CHK;
      S_FB_CHK: begin
        if (stat.rd_free) begin
          cmd.op     = OP_FREE_BACK;
          state_next = stat.ptr_zero ? S_FW_SETUP : S_FB_RD;
        end else begin
          state_next = S_FW_SETUP;
        end
      end
      S_FW_SETUP: begin
        cmd.op     = OP_FILL_SETUP;
        state_next = S_FW;
      end
      S_FW: begin
        cmd.op = OP_FREE_FILL;
        if (stat.fill_last) begin
          code_next  = ST_OK;
          state_next = S_REPORT;
        end
      end
      S_CLR: begin
        cmd.op = OP_SWEEP;
        if (stat.sweep_last) begin
          code_next  = ST_OK;
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        cmd.op     = OP_REPORT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/core/cra_dp.sv
// datapath of the cell run allocator: cell table, walk pointer, counters
module cra_dp
  import cra_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  input  logic [1:0]          command,
  input  logic [BYTES_W-1:0]  request_bytes,
  input  logic [CELL_W-1:0]   start_cell,
  input  logic [BYTES_W-1:0]  free_offset,
  input  logic [LG_W-1:0]     lg,
  input  logic [RUN_W-1:0]    n,
  output dp_stat_t            stat,
  output logic                done,
  output logic [1:0]          status,
  output logic [OFF_W-1:0]    chunk_offset,
  output logic [RUN_W-1:0]    taken_total,
  output logic [CNT_W-1:0]    alloc_call_count,
  output logic [CNT_W-1:0]    alloc_fail_count,
  output logic [CNT_W-1:0]    free_call_count,
  output logic [CNT_W-1:0]    free_fail_count
);

  // cell table: top bit free flag, low bits run length
  logic [RUN_W:0] mem [MAX_CELLS];
  logic [RUN_W:0] rd_q;
  logic           we;
  logic [RUN_W:0] wdata;

  // latched item and walk registers
  cmd_t               cmd_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [CELL_W-1:0]  start_q;
  logic [BYTES_W-1:0] off_q;
  logic [PTR_W-1:0]   ptr;
  logic [RUN_W-1:0]   j;
  logic [RUN_W-1:0]   nc;
  logic [CELL_W-1:0]  found;
  logic [CELL_W-1:0]  cellq;
  logic [PTR_W-1:0]   last;
  logic [CELL_W-1:0]  first;
  logic [RUN_W-1:0]   saved;

  // combinational terms
  logic               rd_flag;
  logic [RUN_W-1:0]   rd_run;
  logic [LG_MAX-1:0]  cs_mask;
  logic [BYTES_W:0]   pool_bytes;
  logic [BYTES_W:0]   req_round;
  logic [RUN_W-1:0]   nc_calc;
  logic [CELL_W-1:0]  cell_calc;
  logic [PTR_W-1:0]   n_ext;
  logic [PTR_W-1:0]   adv;
  logic [PTR_W-1:0]   hsum;
  logic [PTR_W-1:0]   hclamp;
  logic               head_short;
  logic [PTR_W-1:0]   msum;
  logic [PTR_W-1:0]   mclamp;
  logic [PTR_W-1:0]   sweep_run;
  logic [PTR_W-1:0]   fill_run;
  logic [PTR_W-1:0]   tsum;
  logic               is_alloc;

  assign rd_flag    = rd_q[RUN_W];
  assign rd_run     = rd_q[RUN_W-1:0];
  assign n_ext      = PTR_W'(n);
  assign cs_mask    = ~({LG_MAX{1'b1}} << lg);
  assign pool_bytes = (BYTES_W+1)'(n) << lg;
  assign req_round  = {1'b0, bytes_q} + (BYTES_W+1)'(cs_mask);
  assign nc_calc    = RUN_W'(req_round >> lg);
  assign cell_calc  = CELL_W'(off_q >> lg);
  assign adv        = ptr + ((rd_run == '0) ? PTR_W'(1) : PTR_W'(rd_run));
  assign hsum       = PTR_W'(cellq) + PTR_W'(rd_run);
  assign hclamp     = (hsum > n_ext) ? n_ext : hsum;
  assign head_short = (hsum <= PTR_W'(cellq));
  assign msum       = last + PTR_W'(rd_run);
  assign mclamp     = (msum > n_ext) ? n_ext : msum;
  assign sweep_run  = (ptr < n_ext) ? (n_ext - ptr) : '0;
  assign fill_run   = last - ptr;
  assign tsum       = PTR_W'(taken_total) + PTR_W'(nc);
  assign is_alloc   = (cmd_q == CMD_ALLOC_FIRST) || (cmd_q == CMD_ALLOC_AT);

  // status to the controller
  always_comb begin
    stat.cmd        = cmd_q;
    stat.req_bad    = (bytes_q == '0) || ({1'b0, bytes_q} > pool_bytes);
    stat.at_bad     = (RUN_W'(start_q) >= n);
    stat.free_bad   = ({1'b0, off_q} >= pool_bytes) ||
                      ((off_q[LG_MAX-1:0] & cs_mask) != '0);
    stat.fit        = rd_flag && (rd_run >= nc) && ((ptr + PTR_W'(nc)) <= n_ext);
    stat.ff_end     = (adv >= n_ext);
    stat.rd_free    = rd_flag;
    stat.ptr_zero   = (ptr == '0);
    stat.take_last  = (j == nc - RUN_W'(1));
    stat.head_merge = !head_short && (hclamp < n_ext);
    stat.cell_zero  = (cellq == '0);
    stat.fill_last  = (ptr + PTR_W'(1) == last);
    stat.sweep_last = (ptr == PTR_W'(MAX_CELLS - 1));
  end

  // table write port
  always_comb begin
    we    = 1'b0;
    wdata = '0;
    case (cmd.op)
      OP_SWEEP: begin
        we    = 1'b1;
        wdata = {1'b1, RUN_W'(sweep_run)};
      end
      OP_BACK_STEP: begin
        we    = 1'b1;
        wdata = {1'b1, j};
      end
      OP_TAKE_STEP: begin
        we    = 1'b1;
        wdata = {1'b0, nc - j};
      end
      OP_FREE_FILL: begin
        we    = 1'b1;
        wdata = {1'b1, RUN_W'(fill_run)};
      end
      default: we = 1'b0;
    endcase
  end

  // cell table with registered read at the walk pointer
  always_ff @(posedge clk) begin
    if (we) mem[ptr[CELL_W-1:0]] <= wdata;
    rd_q <= mem[ptr[CELL_W-1:0]];
  end

  // control registers: pointer, totals, counters, strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr              <= '0;
      taken_total      <= '0;
      alloc_call_count <= '0;
      alloc_fail_count <= '0;
      free_call_count  <= '0;
      free_fail_count  <= '0;
      done             <= 1'b0;
    end else begin
      done <= 1'b0;
      case (cmd.op)
        OP_LATCH: begin
          ptr <= '0;
          if (command == CMD_ALLOC_FIRST || command == CMD_ALLOC_AT)
            alloc_call_count <= alloc_call_count + CNT_W'(1);
        end
        OP_SWEEP: ptr <= ptr + PTR_W'(1);
        OP_ALLOC_SETUP: ptr <= (cmd_q == CMD_ALLOC_AT) ? PTR_W'(start_q) : '0;
        OP_AT_ACCEPT: ptr <= ptr - PTR_W'(1);
        OP_BACK_STEP: ptr <= ptr - PTR_W'(1);
        OP_FF_STEP: if (!stat.fit) ptr <= adv;
        OP_TAKE_SETUP: ptr <= PTR_W'(found);
        OP_TAKE_STEP: begin
          ptr <= ptr + PTR_W'(1);
          if (stat.take_last)
            taken_total <= (tsum > PTR_W'({RUN_W{1'b1}})) ? {RUN_W{1'b1}} : RUN_W'(tsum);
        end
        OP_FREE_SETUP: begin
          ptr <= PTR_W'(cell_calc);
          if ({1'b0, off_q} < pool_bytes)
            free_call_count <= free_call_count + CNT_W'(1);
        end
        OP_FREE_HEAD: ptr <= hclamp;
        OP_FREE_BACK_SETUP: ptr <= PTR_W'(cellq) - PTR_W'(1);
        OP_FREE_BACK: ptr <= ptr - PTR_W'(1);
        OP_FILL_SETUP: ptr <= PTR_W'(first);
        OP_FREE_FILL: begin
          ptr <= ptr + PTR_W'(1);
          if (stat.fill_last)
            taken_total <= (taken_total > saved) ? taken_total - saved : '0;
        end
        OP_REPORT: begin
          done <= 1'b1;
          if (cmd.code != ST_OK) begin
            if (is_alloc) alloc_fail_count <= alloc_fail_count + CNT_W'(1);
            else          free_fail_count  <= free_fail_count + CNT_W'(1);
          end
        end
        default: ptr <= ptr;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        cmd_q   <= cmd_t'(command);
        bytes_q <= request_bytes;
        start_q <= start_cell;
        off_q   <= free_offset;
      end
      OP_ALLOC_SETUP: nc <= nc_calc;
      OP_AT_ACCEPT: begin
        found <= ptr[CELL_W-1:0];
        j     <= RUN_W'(1);
      end
      OP_BACK_STEP: j <= j + RUN_W'(1);
      OP_FF_STEP: if (stat.fit) found <= ptr[CELL_W-1:0];
      OP_TAKE_SETUP: j <= '0;
      OP_TAKE_STEP: j <= j + RUN_W'(1);
      OP_FREE_SETUP: cellq <= cell_calc;
      OP_FREE_HEAD: begin
        saved <= rd_run;
        last  <= head_short ? PTR_W'(cellq) + PTR_W'(1) : hclamp;
      end
      OP_FREE_MERGE: if (rd_flag) last <= mclamp;
      OP_FREE_BACK_SETUP: first <= cellq;
      OP_FREE_BACK: first <= ptr[CELL_W-1:0];
      OP_REPORT: begin
        status       <= cmd.code;
        chunk_offset <= (cmd.code == ST_OK && is_alloc) ?
                        (OFF_W'(found) << lg) : '0;
      end
      default: found <= found;
    endcase
  end

`ifndef NO_ASSERTIONS
  // table writes stay inside the cell table
  ap_we_in_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (ptr < PTR_W'(MAX_CELLS)))
    else $error("cell table write outside the pool");

  // a result strobe follows a report command
  ap_done_from_report: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.op == OP_REPORT))
    else $error("result strobe without report");

  // failure counters move only with a result
  ap_fail_with_result: assert property (@(posedge clk) disable iff (rst)
    (!$stable(alloc_fail_count) || !$stable(free_fail_count)) |-> done)
    else $error("failure counter moved without a result");
`endif

endmodule

>>> rtl/core/cell_run_first_fit_allocator.sv
// Cell run first-fit allocator: one command item is taken when start is high and busy is
// low; its result appears for exactly one cycle with done high and cannot be held off.
// Each command walks a 256-entry cell table with a single read port; each cell read sets
// the address, then uses the registered data. First-fit allocation visits free and taken
// runs and then writes each allocated cell; allocation at a cell also merges the free cells
// below it; free scans back over cells and rewrites cells; clear rewrites all 256 cells.
// After reset a fill of all 256 table cells runs with busy high before the first item is
// taken; write configuration only while busy is low and no result is pending, since a
// command in progress reads it on every cycle.
module cell_run_first_fit_allocator
  import cra_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           command,
  input  logic [BYTES_W-1:0]   request_bytes,
  input  logic [CELL_W-1:0]    start_cell,
  input  logic [BYTES_W-1:0]   free_offset,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 done,
  output logic [1:0]           status,
  output logic [OFF_W-1:0]     chunk_offset,
  output logic [RUN_W-1:0]     taken_total,
  output logic [CNT_W-1:0]     alloc_call_count,
  output logic [CNT_W-1:0]     alloc_fail_count,
  output logic [CNT_W-1:0]     free_call_count,
  output logic [CNT_W-1:0]     free_fail_count
);

  logic [LG_W-1:0]  cell_size_log2;
  logic [CFG_W-1:0] cells_in_use;
  logic [LG_W-1:0]  lg_eff;
  logic [RUN_W-1:0] n_eff;
  dp_cmd_t          dp_cmd;
  dp_stat_t         dp_stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size_log2 <= LG_W'(6);
      cells_in_use   <= CFG_W'(MAX_CELLS);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CELL_SIZE_LOG2: cell_size_log2 <= cfg_data[LG_W-1:0];
        REG_CELLS_IN_USE:   cells_in_use   <= cfg_data;
        default:            cells_in_use   <= cells_in_use;
      endcase
    end
  end

  // clamp configuration to the usable range
  assign lg_eff = (cell_size_log2 > LG_W'(LG_MAX)) ? LG_W'(LG_MAX) : cell_size_log2;
  assign n_eff  = (cells_in_use == '0) ? RUN_W'(1) :
                  (cells_in_use > CFG_W'(MAX_CELLS)) ? RUN_W'(MAX_CELLS) :
                  RUN_W'(cells_in_use);

  cra_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (dp_stat),
    .cmd  (dp_cmd),
    .busy (busy)
  );

  cra_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (dp_cmd),
    .command         (command),
    .request_bytes   (request_bytes),
    .start_cell      (start_cell),
    .free_offset     (free_offset),
    .lg              (lg_eff),
    .n               (n_eff),
    .stat            (dp_stat),
    .done            (done),
    .status          (status),
    .chunk_offset    (chunk_offset),
    .taken_total     (taken_total),
    .alloc_call_count(alloc_call_count),
    .alloc_fail_count(alloc_fail_count),
    .free_call_count (free_call_count),
    .free_fail_count (free_fail_count)
  );

endmodule
